/* src/arithmetic_expression_tokenizer_top_macros.svh */
// assertion macros for the expression tokenizer
// used by arithmetic_expression_tokenizer_top; expects clk and rst_n in scope
`ifndef ARITHMETIC_EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`define ARITHMETIC_EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AET_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AET_ASSERT_SAME(label, ante, cons)
`define AET_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/aet_pkg.sv */
// shared types and constants of the expression tokenizer
// no dependencies
package aet_pkg;

  localparam int TOKEN_LIMIT_DEF = 256;
  localparam int LIT_W = 63;
  localparam logic [LIT_W-1:0] LIT_MAX = {LIT_W{1'b1}};

  localparam logic [2:0] TK_LITERAL  = 3'd0;
  localparam logic [2:0] TK_OPERATOR = 3'd1;
  localparam logic [2:0] TK_OPEN     = 3'd2;
  localparam logic [2:0] TK_CLOSE    = 3'd3;
  localparam logic [2:0] TK_UNKNOWN  = 3'd4;
  localparam logic [2:0] TK_END      = 3'd5;
  localparam logic [2:0] TK_ERROR    = 3'd6;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] PREC_NONE     = 2'd0;
  localparam logic [1:0] PREC_ADDITIVE = 2'd1;
  localparam logic [1:0] PREC_PRODUCT  = 2'd2;
  localparam logic [1:0] PREC_GROUP    = 2'd3;

  localparam logic IN_CHAR = 1'b0;
  localparam logic IN_END  = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       token_kind;
    logic [LIT_W-1:0] literal_value;
    logic [2:0]       operator_code;
    logic [1:0]       precedence;
    logic [7:0]       unknown_char;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [LIT_W-1:0] acc;
    logic             in_num;
    logic             failed;
  } lex_state_t;

endpackage

/* src/aet_step.sv */
// next-state and token logic for one character or end marker
// depends on aet_pkg
module aet_step #(
  parameter int TOKEN_LIMIT = aet_pkg::TOKEN_LIMIT_DEF
) (
  input  aet_pkg::in_item_t                item,
  input  aet_pkg::lex_state_t              st,
  input  logic [$clog2(TOKEN_LIMIT)-1:0]   tok_cnt,
  output aet_pkg::lex_state_t              st_nxt,
  output logic [$clog2(TOKEN_LIMIT)-1:0]   tok_cnt_nxt,
  output aet_pkg::out_item_t               res0,
  output aet_pkg::out_item_t               res1,
  output logic [1:0]                       n_res
);

  localparam int CntW = $clog2(TOKEN_LIMIT);
  localparam logic [CntW:0] CntLast = (CntW+1)'(TOKEN_LIMIT - 1);

  logic                        digit;
  logic [3:0]                  dval;
  logic [aet_pkg::LIT_W+3:0]   prod;
  logic [aet_pkg::LIT_W-1:0]   acc_step;
  logic [CntW:0]               cnt_eff;
  logic                        emit_lit;
  logic                        emit_tok;
  aet_pkg::out_item_t          lit_res;
  aet_pkg::out_item_t          tok_res;

  assign digit = item.char_code inside {[aet_pkg::CH_0:aet_pkg::CH_9]};
  assign dval  = 4'(item.char_code - aet_pkg::CH_0);

  // acc * 10 + d as two shifted adds, saturating
  assign prod = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0}
              + {(aet_pkg::LIT_W)'(0), dval};
  assign acc_step = (prod[aet_pkg::LIT_W+3:aet_pkg::LIT_W] != 4'd0) ? aet_pkg::LIT_MAX
                  : prod[aet_pkg::LIT_W-1:0];

  always_comb begin
    lit_res = '0;
    lit_res.token_kind    = aet_pkg::TK_LITERAL;
    lit_res.literal_value = st.acc;
  end

  always_comb begin
    st_nxt      = st;
    tok_cnt_nxt = tok_cnt;
    emit_lit    = 1'b0;
    emit_tok    = 1'b0;
    tok_res     = '0;
    cnt_eff     = {1'b0, tok_cnt};
    if (item.kind == aet_pkg::IN_END) begin
      if (!st.failed) begin
        emit_lit           = st.in_num;
        emit_tok           = 1'b1;
        tok_res.token_kind = aet_pkg::TK_END;
        tok_res.last       = 1'b1;
      end
      st_nxt      = '0;
      tok_cnt_nxt = '0;
    end else if (!st.failed) begin
      if (st.in_num && digit) begin
        st_nxt.acc = acc_step;
      end else begin
        emit_lit = st.in_num;
        cnt_eff  = {1'b0, tok_cnt} + (CntW+1)'(st.in_num);
        st_nxt.in_num = 1'b0;
        st_nxt.acc    = '0;
        tok_cnt_nxt   = cnt_eff[CntW-1:0];
        if (cnt_eff == CntLast) begin
          emit_tok           = 1'b1;
          tok_res.token_kind = aet_pkg::TK_ERROR;
          tok_res.last       = 1'b1;
          st_nxt.failed      = 1'b1;
        end else if (digit) begin
          st_nxt.in_num = 1'b1;
          st_nxt.acc    = (aet_pkg::LIT_W)'(dval);
        end else if (item.char_code != aet_pkg::CH_SPACE) begin
          emit_tok    = 1'b1;
          tok_cnt_nxt = CntW'(cnt_eff + (CntW+1)'(1));
          case (item.char_code)
            aet_pkg::CH_PLUS: begin
              tok_res.token_kind    = aet_pkg::TK_OPERATOR;
              tok_res.operator_code = aet_pkg::OP_ADD;
              tok_res.precedence    = aet_pkg::PREC_ADDITIVE;
            end
            aet_pkg::CH_MINUS: begin
              tok_res.token_kind    = aet_pkg::TK_OPERATOR;
              tok_res.operator_code = aet_pkg::OP_SUB;
              tok_res.precedence    = aet_pkg::PREC_ADDITIVE;
            end
            aet_pkg::CH_STAR: begin
              tok_res.token_kind    = aet_pkg::TK_OPERATOR;
              tok_res.operator_code = aet_pkg::OP_MUL;
              tok_res.precedence    = aet_pkg::PREC_PRODUCT;
            end
            aet_pkg::CH_SLASH: begin
              tok_res.token_kind    = aet_pkg::TK_OPERATOR;
              tok_res.operator_code = aet_pkg::OP_DIV;
              tok_res.precedence    = aet_pkg::PREC_PRODUCT;
            end
            aet_pkg::CH_OPEN: begin
              tok_res.token_kind = aet_pkg::TK_OPEN;
              tok_res.precedence = aet_pkg::PREC_GROUP;
            end
            aet_pkg::CH_CLOSE: begin
              tok_res.token_kind = aet_pkg::TK_CLOSE;
              tok_res.precedence = aet_pkg::PREC_GROUP;
            end
            default: begin
              tok_res.token_kind   = aet_pkg::TK_UNKNOWN;
              tok_res.unknown_char = item.char_code;
            end
          endcase
        end
      end
    end
  end

  // a pending literal always goes out ahead of the other token
  assign res0  = emit_lit ? lit_res : tok_res;
  assign res1  = tok_res;
  assign n_res = {1'b0, emit_lit} + {1'b0, emit_tok};

endmodule

/* src/arithmetic_expression_tokenizer_top.sv */
// top level of the arithmetic expression tokenizer
// depends on aet_pkg, aet_step and arithmetic_expression_tokenizer_top_macros.svh
//
// Input channel (in_valid, in_stall, in_data): one expression character per
// item, or an end marker (kind set) that closes the expression.
// Output channel (out_valid, out_stall, out_data): token items; end and error
// tokens carry last. An item gives zero, one or two tokens.
// Each accepted item is decoded in the cycle it is taken; its tokens enter a
// three-entry result queue whose head drives out_data. When the queue is empty, the
// first token reaches the output in the cycle after the accept.
// Throughput: one item per cycle as long as the queue holds at most one token;
// in_stall rises when two or more tokens are waiting, so items that produce
// two tokens are limited by the output side to one token per cycle.
// A run of digits produces its literal only when the following non-digit or
// end marker arrives.
// Reset clears the lexer state, the token counter and the queue.
// When the receiver stalls, the head token holds and the queue fills; input
// is then stalled until the queue drains below two entries.
`include "arithmetic_expression_tokenizer_top_macros.svh"
module arithmetic_expression_tokenizer_top #(
  parameter int TOKEN_LIMIT = aet_pkg::TOKEN_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aet_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aet_pkg::out_item_t out_data
);

  localparam int CntW = $clog2(TOKEN_LIMIT);
  localparam int QDepth = 3;

  aet_pkg::lex_state_t st_r, st_nxt;
  logic [CntW-1:0]     tok_cnt_r, tok_cnt_nxt;
  aet_pkg::out_item_t  res0, res1;
  logic [1:0]          n_res;

  aet_pkg::out_item_t  q_r [QDepth];
  aet_pkg::out_item_t  q_nxt [QDepth];
  logic [1:0]          qcnt_r, qcnt_nxt;
  logic [1:0]          base;
  logic                in_fire, out_fire;

  aet_step #(
    .TOKEN_LIMIT(TOKEN_LIMIT)
  ) u_step (
    .item       (in_data),
    .st         (st_r),
    .tok_cnt    (tok_cnt_r),
    .st_nxt     (st_nxt),
    .tok_cnt_nxt(tok_cnt_nxt),
    .res0       (res0),
    .res1       (res1),
    .n_res      (n_res)
  );

  assign in_stall  = (qcnt_r > 2'd1);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (qcnt_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;
  assign out_data  = q_r[0];

  assign base = qcnt_r - {1'b0, out_fire};

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (out_fire && i < QDepth - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (in_fire && n_res != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = res0;
      end
      if (in_fire && n_res == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = res1;
      end
    end
    qcnt_nxt = base + (in_fire ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      tok_cnt_r <= '0;
      qcnt_r    <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (in_fire) begin
        st_r      <= st_nxt;
        tok_cnt_r <= tok_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  `AET_ASSERT_SAME(a_cnt_bound, 1'b1, tok_cnt_r <= CntW'(TOKEN_LIMIT - 1))
  `AET_ASSERT_NEXT(a_end_clears, in_fire && in_data.kind == aet_pkg::IN_END, tok_cnt_r == '0 && !st_r.in_num && !st_r.failed)
  `AET_ASSERT_SAME(a_last_no_lit, out_valid && out_data.last, out_data.literal_value == '0)
  `AET_ASSERT_NEXT(a_drain_only, out_fire && !in_fire, qcnt_r == $past(qcnt_r) - 2'd1)

endmodule

/* tb/sv/tb_arithmetic_expression_tokenizer_top.sv */
`timescale 1ns / 1ps
// testbench for arithmetic_expression_tokenizer_top: streams expressions with random pacing
// and checks every token against a scoreboard that lexes the same items; depends on aet_pkg
module tb_arithmetic_expression_tokenizer_top;
  import aet_pkg::*;

  class token_scoreboard;
    out_item_t        expected_tokens[$];
    logic [LIT_W-1:0] acc;
    logic             in_num;
    logic             discarding;
    int               tokens_in_expr;
    int               mismatches;
    int               checked;
    int               limit_errors;
    int               saturations;

    function new();
      clear_expression();
      mismatches   = 0;
      checked      = 0;
      limit_errors = 0;
      saturations  = 0;
    endfunction

    function void clear_expression();
      acc            = '0;
      in_num         = 1'b0;
      discarding     = 1'b0;
      tokens_in_expr = 0;
    endfunction

    function void expect_token(logic [2:0] kind, logic [LIT_W-1:0] lit, logic [2:0] op,
                               logic [1:0] prec, logic [7:0] uc, logic last);
      out_item_t t;
      t.token_kind    = kind;
      t.literal_value = lit;
      t.operator_code = op;
      t.precedence    = prec;
      t.unknown_char  = uc;
      t.last          = last;
      expected_tokens.push_back(t);
    endfunction

    function void lex_item(in_item_t it);
      logic [7:0]  c;
      logic        is_digit;
      logic [63:0] d;
      logic [63:0] wide;
      c        = it.char_code;
      is_digit = (c >= CH_0) && (c <= CH_9);
      d        = 64'(c - CH_0);
      if (it.kind == IN_END) begin
        if (!discarding) begin
          if (in_num) expect_token(TK_LITERAL, acc, OP_NONE, PREC_NONE, 8'h00, 1'b0);
          expect_token(TK_END, '0, OP_NONE, PREC_NONE, 8'h00, 1'b1);
        end
        clear_expression();
        return;
      end
      if (discarding) return;
      if (in_num) begin
        if (is_digit) begin
          if ({1'b0, acc} > ({1'b0, LIT_MAX} - d) / 64'd10) begin
            acc = LIT_MAX;
            saturations++;
          end else begin
            wide = {1'b0, acc} * 64'd10 + d;
            acc  = wide[LIT_W-1:0];
          end
          return;
        end
        expect_token(TK_LITERAL, acc, OP_NONE, PREC_NONE, 8'h00, 1'b0);
        acc    = '0;
        in_num = 1'b0;
        tokens_in_expr++;
      end
      if (tokens_in_expr >= TOKEN_LIMIT_DEF - 1) begin
        expect_token(TK_ERROR, '0, OP_NONE, PREC_NONE, 8'h00, 1'b1);
        discarding = 1'b1;
        limit_errors++;
        return;
      end
      if (c == CH_SPACE) return;
      if (is_digit) begin
        in_num = 1'b1;
        acc    = LIT_W'(d);
        return;
      end
      case (c)
        CH_PLUS:  expect_token(TK_OPERATOR, '0, OP_ADD, PREC_ADDITIVE, 8'h00, 1'b0);
        CH_MINUS: expect_token(TK_OPERATOR, '0, OP_SUB, PREC_ADDITIVE, 8'h00, 1'b0);
        CH_STAR:  expect_token(TK_OPERATOR, '0, OP_MUL, PREC_PRODUCT, 8'h00, 1'b0);
        CH_SLASH: expect_token(TK_OPERATOR, '0, OP_DIV, PREC_PRODUCT, 8'h00, 1'b0);
        CH_OPEN:  expect_token(TK_OPEN, '0, OP_NONE, PREC_GROUP, 8'h00, 1'b0);
        CH_CLOSE: expect_token(TK_CLOSE, '0, OP_NONE, PREC_GROUP, 8'h00, 1'b0);
        default:  expect_token(TK_UNKNOWN, '0, OP_NONE, PREC_NONE, c, 1'b0);
      endcase
      tokens_in_expr++;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_token(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token kind %0d with nothing expected", got.token_kind));
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (got.token_kind !== want.token_kind || got.literal_value !== want.literal_value ||
          got.operator_code !== want.operator_code || got.precedence !== want.precedence ||
          got.unknown_char !== want.unknown_char || got.last !== want.last)
        report_mismatch($sformatf(
          "got kind %0d lit %0d op %0d prec %0d char %02h last %0b, want %0d %0d %0d %0d %02h %0b",
          got.token_kind, got.literal_value, got.operator_code, got.precedence,
          got.unknown_char, got.last, want.token_kind, want.literal_value,
          want.operator_code, want.precedence, want.unknown_char, want.last));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  token_scoreboard sb = new();
  bit calm;
  bit steady;
  int items_sent;
  int exprs;

  arithmetic_expression_tokenizer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.lex_item(in_data);
      if (out_valid && !out_stall) sb.check_token(out_data);
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] code);
    in_item_t it;
    it.kind      = kind;
    it.char_code = code;
    if (!calm && !steady && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic [7:0] token_char();
    case ($urandom_range(0, 8))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_OPEN;
      5:       return CH_CLOSE;
      6:       return 8'h09;
      7:       return 8'(8'h61 + $urandom_range(0, 25));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic send_digits(input int len);
    for (int i = 0; i < len; i++) send_item(IN_CHAR, 8'(CH_0 + $urandom_range(0, 9)));
  endtask

  task automatic send_expression(input bit long_form);
    int steps;
    int pick;
    steady = ($urandom_range(0, 3) == 0);
    if (long_form) begin
      steps = $urandom_range(252, 266);
      for (int s = 0; s < steps; s++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_item(IN_CHAR, CH_SPACE);
        if (pick == 1) send_digits($urandom_range(1, 3));
        else send_item(IN_CHAR, token_char());
      end
      repeat ($urandom_range(0, 5)) send_item(IN_CHAR, 8'($urandom_range(0, 255)));
    end else begin
      steps = $urandom_range(0, 14);
      for (int s = 0; s < steps; s++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) send_item(IN_CHAR, CH_SPACE);
        else if (pick <= 3)
          send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 4));
        else if (pick <= 8) send_item(IN_CHAR, token_char());
        else send_item(IN_CHAR, 8'($urandom_range(0, 255)));
      end
    end
    send_item(IN_END, 8'($urandom_range(0, 255)));
    exprs++;
  endtask

  initial begin : rx_pacing
    int pick;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 9);
      if (!calm && pick < 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (pick == 9) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    calm       = 1'b0;
    steady     = 1'b0;
    items_sent = 0;
    exprs      = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every operator, brackets, space, tab, extreme codes, literal closed by end
    send_item(IN_CHAR, CH_OPEN);
    send_item(IN_CHAR, 8'h37);
    send_item(IN_CHAR, CH_PLUS);
    send_item(IN_CHAR, CH_SPACE);
    send_item(IN_CHAR, CH_0);
    send_item(IN_CHAR, CH_CLOSE);
    send_item(IN_CHAR, CH_STAR);
    send_item(IN_CHAR, CH_9);
    send_item(IN_CHAR, CH_SLASH);
    send_item(IN_CHAR, CH_MINUS);
    send_item(IN_CHAR, 8'hFF);
    send_item(IN_CHAR, 8'h00);
    send_item(IN_CHAR, 8'h09);
    send_item(IN_CHAR, 8'h35);
    send_item(IN_END, 8'hA5);
    // empty expression
    send_item(IN_END, 8'h00);
    exprs = 2;

    while (items_sent < 950) begin
      calm = (items_sent >= 820);
      send_expression(exprs % 16 == 3);
    end
    in_valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d items in %0d expressions gave %0d checked tokens", items_sent, exprs,
             sb.checked);
    $display("token limit hit %0d times, literal saturation seen %0d times",
             sb.limit_errors, sb.saturations);
    if (sb.mismatches == 0) begin
      $display("arithmetic_expression_tokenizer_top: match");
    end else begin
      $display("arithmetic_expression_tokenizer_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("arithmetic_expression_tokenizer_top: mismatch");
    $finish;
  end
endmodule
